FILE: hdl/obr_pkg.sv
// Shared types and constants for the overwriting byte ring buffer.
package obr_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int CALC_W    = 10;
	localparam int LEN_W     = 9;

	localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(256);
	localparam logic [CALC_W-1:0] FIND_MAX  = CALC_W'(256);

	typedef enum logic [2:0] {
		OP_WRITE = 3'd0,
		OP_READ  = 3'd1,
		OP_PEEK  = 3'd2,
		OP_AT    = 3'd3,
		OP_FIND  = 3'd4,
		OP_SEEK  = 3'd5,
		OP_SKIP  = 3'd6,
		OP_FLUSH = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_SCAN,
		ST_RESP
	} state_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  data;
		logic [7:0]  pos;
		logic [15:0] cnt;
	} req_t;

	typedef struct packed {
		logic [7:0]       data;
		logic             found;
		logic [7:0]       offset;
		logic [LEN_W-1:0] fill;
		logic [LEN_W-1:0] free;
		logic             full;
	} rsp_t;

endpackage

FILE: hdl/obr_store.sv
// Byte store: one write port, one read port with registered read data.
module obr_store #(
	parameter int DEPTH = obr_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata
);

	logic [7:0] mem [DEPTH];

	// write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/obr_ctrl.sv
// Sequencer for the ring buffer: pointers, clearing sweep, fetch and scan over the store.
module obr_ctrl #(
	parameter int DEPTH = obr_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr,
	input  logic [obr_pkg::LEN_W-1:0]    ring_len,
	input  logic                         req_valid,
	input  obr_pkg::req_t                req,
	output logic                         req_ready,
	output logic                         rsp_valid,
	output obr_pkg::rsp_t                rsp,
	input  logic                         rsp_ready
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = obr_pkg::CALC_W;
	localparam int LW    = obr_pkg::LEN_W;
	localparam int CLR_N = (DEPTH < 512) ? DEPTH : 512;
	localparam logic [AW-1:0] CLR_LAST = AW'(CLR_N - 1);

	// add within the ring; correct only while neither operand exceeds the length
	function automatic logic [CW-1:0] wrap_add(
		input logic [CW-1:0] a,
		input logic [CW-1:0] b,
		input logic [CW-1:0] len
	);
		logic [CW-1:0] s;
		s = a + b;
		if (s >= len) begin
			s = s - len;
		end
		return s;
	endfunction

	obr_pkg::state_t state_q, state_n;
	logic [AW-1:0]   rp_q, rp_n;
	logic [AW-1:0]   wp_q, wp_n;
	logic            ovr_q, ovr_n;
	logic [AW-1:0]   clr_q, clr_n;
	obr_pkg::op_t    op_q, op_n;
	logic [7:0]      dat_q, dat_n;
	logic [CW-1:0]   lim_q, lim_n;
	logic [CW-1:0]   iss_addr_q, iss_addr_n;
	logic [CW-1:0]   iss_cnt_q, iss_cnt_n;
	logic            cmp_valid_s1, cmp_valid_n;
	logic [CW-1:0]   cmp_cnt_s1, cmp_cnt_n;
	logic [7:0]      res_data_q, res_data_n;
	logic            res_found_q, res_found_n;
	logic [7:0]      res_off_q, res_off_n;

	logic [LW-1:0]   n;
	logic [CW-1:0]   nc, rpc, wpc, fill;
	logic [CW-1:0]   wp_inc, rp_inc, at_addr, skip_len, scan_lim, scan_adv;
	logic            hit, last;

	logic            mem_we, mem_re;
	logic [AW-1:0]   mem_waddr, mem_raddr;
	logic [7:0]      mem_wdata, mem_rdata;

	obr_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// clamp the ring length to 1..DEPTH
	always_comb begin
		if (ring_len == '0) begin
			n = LW'(1);
		end else if (32'(ring_len) > DEPTH) begin
			n = LW'(DEPTH);
		end else begin
			n = ring_len;
		end
	end

	assign nc  = CW'(n);
	assign rpc = CW'(rp_q);
	assign wpc = CW'(wp_q);

	// fill level from the pointers and the overrun mark
	always_comb begin
		if (wpc > rpc) begin
			fill = wpc - rpc;
		end else if (wpc < rpc) begin
			fill = nc - rpc + wpc;
		end else if (ovr_q) begin
			fill = nc;
		end else begin
			fill = '0;
		end
	end

	assign wp_inc   = wrap_add(wpc, CW'(1), nc);
	assign rp_inc   = wrap_add(rpc, CW'(1), nc);
	assign at_addr  = wrap_add(rpc, CW'(req.pos), nc);
	assign skip_len = (req.cnt > 16'(fill)) ? fill : CW'(req.cnt);
	assign scan_lim = (req.op == obr_pkg::OP_FIND && fill > obr_pkg::FIND_MAX) ?
		obr_pkg::FIND_MAX : fill;

	// compare stage of the scan
	assign hit      = cmp_valid_s1 && (mem_rdata == dat_q);
	assign last     = cmp_valid_s1 && (cmp_cnt_s1 == lim_q - CW'(1));
	assign scan_adv = hit ? cmp_cnt_s1 : lim_q;

	assign req_ready = (state_q == obr_pkg::ST_IDLE);
	assign rsp_valid = (state_q == obr_pkg::ST_RESP);

	assign rsp.data   = res_data_q;
	assign rsp.found  = res_found_q;
	assign rsp.offset = res_off_q;
	assign rsp.fill   = LW'(fill);
	assign rsp.free   = n - LW'(fill);
	assign rsp.full   = ovr_q;

	// next state, pointer updates and store accesses
	always_comb begin
		state_n     = state_q;
		rp_n        = rp_q;
		wp_n        = wp_q;
		ovr_n       = ovr_q;
		clr_n       = clr_q;
		op_n        = op_q;
		dat_n       = dat_q;
		lim_n       = lim_q;
		iss_addr_n  = iss_addr_q;
		iss_cnt_n   = iss_cnt_q;
		cmp_valid_n = 1'b0;
		cmp_cnt_n   = cmp_cnt_s1;
		res_data_n  = res_data_q;
		res_found_n = res_found_q;
		res_off_n   = res_off_q;
		mem_we      = 1'b0;
		mem_waddr   = wp_q;
		mem_wdata   = req.data;
		mem_re      = 1'b0;
		mem_raddr   = rp_q;

		unique case (state_q)
			obr_pkg::ST_CLEAR: begin
				// zero one entry a cycle
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				clr_n     = clr_q + AW'(1);
				if (clr_q == CLR_LAST) begin
					state_n = obr_pkg::ST_IDLE;
				end
			end
			obr_pkg::ST_IDLE: begin
				if (req_valid) begin
					op_n        = req.op;
					dat_n       = req.data;
					res_data_n  = '0;
					res_found_n = 1'b0;
					res_off_n   = '0;
					state_n     = obr_pkg::ST_RESP;
					unique case (req.op)
						obr_pkg::OP_WRITE: begin
							mem_we = 1'b1;
							wp_n   = AW'(wp_inc);
							if (ovr_q) begin
								rp_n = AW'(wp_inc);
							end else begin
								ovr_n = (wp_inc == rpc);
							end
						end
						obr_pkg::OP_READ: begin
							if (fill != '0) begin
								mem_re  = 1'b1;
								state_n = obr_pkg::ST_FETCH;
							end
						end
						obr_pkg::OP_PEEK: begin
							mem_re  = 1'b1;
							state_n = obr_pkg::ST_FETCH;
						end
						obr_pkg::OP_AT: begin
							if (CW'(req.pos) < fill) begin
								mem_re    = 1'b1;
								mem_raddr = AW'(at_addr);
								state_n   = obr_pkg::ST_FETCH;
							end
						end
						obr_pkg::OP_FIND, obr_pkg::OP_SEEK: begin
							lim_n      = scan_lim;
							iss_addr_n = rpc;
							iss_cnt_n  = '0;
							if (scan_lim != '0) begin
								state_n = obr_pkg::ST_SCAN;
							end
						end
						obr_pkg::OP_SKIP: begin
							rp_n = AW'(wrap_add(rpc, skip_len, nc));
							if (skip_len != '0) begin
								ovr_n = 1'b0;
							end
						end
						obr_pkg::OP_FLUSH: begin
							rp_n  = wp_q;
							ovr_n = 1'b0;
						end
					endcase
				end
			end
			obr_pkg::ST_FETCH: begin
				// take the word; a read also drops it
				res_data_n = mem_rdata;
				if (op_q == obr_pkg::OP_READ) begin
					rp_n  = AW'(rp_inc);
					ovr_n = 1'b0;
				end
				state_n = obr_pkg::ST_RESP;
			end
			obr_pkg::ST_SCAN: begin
				// issue the next address while the previous word is compared
				if (iss_cnt_q < lim_q) begin
					mem_re      = 1'b1;
					mem_raddr   = AW'(iss_addr_q);
					iss_addr_n  = wrap_add(iss_addr_q, CW'(1), nc);
					iss_cnt_n   = iss_cnt_q + CW'(1);
					cmp_valid_n = 1'b1;
					cmp_cnt_n   = iss_cnt_q;
				end
				if (hit || last) begin
					cmp_valid_n = 1'b0;
					state_n     = obr_pkg::ST_RESP;
					if (op_q == obr_pkg::OP_FIND) begin
						res_found_n = hit;
						res_off_n   = hit ? 8'(cmp_cnt_s1) : 8'd0;
					end else begin
						rp_n = AW'(wrap_add(rpc, scan_adv, nc));
						if (scan_adv != '0) begin
							ovr_n = 1'b0;
						end
					end
				end
			end
			obr_pkg::ST_RESP: begin
				if (rsp_ready) begin
					state_n = obr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = obr_pkg::ST_IDLE;
			end
		endcase

		// a new ring length empties the ring and clears the store
		if (cfg_wr) begin
			state_n     = obr_pkg::ST_CLEAR;
			clr_n       = '0;
			rp_n        = '0;
			wp_n        = '0;
			ovr_n       = 1'b0;
			cmp_valid_n = 1'b0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= obr_pkg::ST_CLEAR;
			rp_q         <= '0;
			wp_q         <= '0;
			ovr_q        <= 1'b0;
			clr_q        <= '0;
			cmp_valid_s1 <= 1'b0;
		end else begin
			state_q      <= state_n;
			rp_q         <= rp_n;
			wp_q         <= wp_n;
			ovr_q        <= ovr_n;
			clr_q        <= clr_n;
			cmp_valid_s1 <= cmp_valid_n;
		end
	end

	// operation and result payload
	always_ff @(posedge clk) begin
		op_q        <= op_n;
		dat_q       <= dat_n;
		lim_q       <= lim_n;
		iss_addr_q  <= iss_addr_n;
		iss_cnt_q   <= iss_cnt_n;
		cmp_cnt_s1  <= cmp_cnt_n;
		res_data_q  <= res_data_n;
		res_found_q <= res_found_n;
		res_off_q   <= res_off_n;
	end

endmodule

FILE: hdl/overwriting_byte_ring_buffer_core.sv
// Top level of the overwriting byte ring buffer: ports, length register and output register.
//
//  channel | direction | handshake           | word
//  cfg     | in        | cfg_valid/cfg_ready | ring_length
//  in      | in        | in_valid/in_ready   | operation, data_byte, position, skip_count
//  out     | out       | out_valid/out_ready | data_out, found, found_offset, fill_level,
//          |           |                     | free_space, full_flag
//
// Write, skip and flush answer straight from the idle state. Peek passes through a fetch state
// for the registered read of the byte store, and so do read and fetch at offset when a byte is
// returned. Find and seek answer at once on an empty ring, else they scan the held bytes.
// After reset and after every ring_length write, a clearing sweep over min(DEPTH, 512) entries
// zeroes the store while in_ready is low; cfg_ready stays high. A result waits in the output
// register while out_ready is low, and the next word is still taken.
module overwriting_byte_ring_buffer_core #(
	parameter int DEPTH = obr_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [obr_pkg::LEN_W-1:0] ring_length,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [2:0]                operation,
	input  logic [7:0]                data_byte,
	input  logic [7:0]                position,
	input  logic [15:0]               skip_count,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                data_out,
	output logic                      found,
	output logic [7:0]                found_offset,
	output logic [obr_pkg::LEN_W-1:0] fill_level,
	output logic [obr_pkg::LEN_W-1:0] free_space,
	output logic                      full_flag
);

	logic [obr_pkg::LEN_W-1:0] len_q;
	logic                      cfg_wr;
	obr_pkg::req_t             req;
	obr_pkg::rsp_t             rsp;
	obr_pkg::rsp_t             out_q;
	logic                      rsp_valid, rsp_ready;
	logic                      out_valid_q;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// hold the ring length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= obr_pkg::LEN_RESET;
		end else if (cfg_wr) begin
			len_q <= ring_length;
		end
	end

	assign req.op   = obr_pkg::op_t'(operation);
	assign req.data = data_byte;
	assign req.pos  = position;
	assign req.cnt  = skip_count;

	obr_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.ring_len  (len_q),
		.req_valid (in_valid),
		.req       (req),
		.req_ready (in_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.rsp_ready (rsp_ready)
	);

	// output register: load when empty or being drained
	assign rsp_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_valid && rsp_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			out_q <= rsp;
		end
	end

	assign out_valid    = out_valid_q;
	assign data_out     = out_q.data;
	assign found        = out_q.found;
	assign found_offset = out_q.offset;
	assign fill_level   = out_q.fill;
	assign free_space   = out_q.free;
	assign full_flag    = out_q.full;

endmodule

FILE: bench/overwriting_byte_ring_buffer_core_tb.sv
// Self-checking testbench for the overwriting byte ring buffer core.
`timescale 1ns / 1ps

module overwriting_byte_ring_buffer_core_tb;
	import obr_pkg::*;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int STORE_SIZE  = 256;

	// Clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Block inputs, known from time zero
	logic             cfg_valid   = 1'b0;
	logic [LEN_W-1:0] ring_length = LEN_W'(256);
	logic             in_valid    = 1'b0;
	logic [2:0]       operation   = OP_READ;
	logic [7:0]       data_byte   = 8'h00;
	logic [7:0]       position    = 8'h00;
	logic [15:0]      skip_count  = 16'h0000;
	logic             out_ready   = 1'b0;

	// Block outputs
	logic             cfg_ready;
	logic             in_ready;
	logic             out_valid;
	logic [7:0]       data_out;
	logic             found;
	logic [7:0]       found_offset;
	logic [LEN_W-1:0] fill_level;
	logic [LEN_W-1:0] free_space;
	logic             full_flag;

	// Directed stimulus row: a word, and the status typed in where it is obvious
	typedef struct {
		op_t         op;
		logic [7:0]  d;
		logic [7:0]  p;
		logic [15:0] c;
		bit          typed;
		rsp_t        want;
	} plan_row_t;

	plan_row_t plan [25];

	// Mirror of the ring
	logic [7:0]       ring_mem [STORE_SIZE];
	int unsigned      rd_ptr;
	int unsigned      wr_ptr;
	bit               overrun;
	logic [LEN_W-1:0] len_reg;

	rsp_t pending_words [$];
	int   fail_count = 0;
	int   cycles     = 0;
	int   write_pct  = 50;
	bit   tx_idle    = 1'b1;
	bit   rx_idle    = 1'b1;

	always #5 clk = ~clk;

	overwriting_byte_ring_buffer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.ring_length  (ring_length),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.data_byte    (data_byte),
		.position     (position),
		.skip_count   (skip_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_out     (data_out),
		.found        (found),
		.found_offset (found_offset),
		.fill_level   (fill_level),
		.free_space   (free_space),
		.full_flag    (full_flag)
	);

	// Clamp the configured length to 1..256
	function automatic int unsigned ring_span();
		int unsigned n;
		n = len_reg;
		if (n == 0) n = 1;
		if (n > STORE_SIZE) n = STORE_SIZE;
		return n;
	endfunction

	function automatic int unsigned bytes_held();
		if (wr_ptr > rd_ptr) return wr_ptr - rd_ptr;
		if (wr_ptr < rd_ptr) return ring_span() - rd_ptr + wr_ptr;
		return overrun ? ring_span() : 0;
	endfunction

	// Drop up to k oldest bytes; any drop clears the overrun mark
	function automatic void drop_oldest(int unsigned k);
		int unsigned have;
		have = bytes_held();
		if (k > have) k = have;
		if (k == 0) return;
		rd_ptr  = (rd_ptr + k) % ring_span();
		overrun = 1'b0;
	endfunction

	// A length write empties the ring and clears the store
	function automatic void apply_length(logic [LEN_W-1:0] v);
		len_reg = v;
		foreach (ring_mem[i]) ring_mem[i] = 8'h00;
		rd_ptr  = 0;
		wr_ptr  = 0;
		overrun = 1'b0;
	endfunction

	// Advance the mirror by one word and return the status it should produce
	function automatic rsp_t ring_predict(op_t op, logic [7:0] d, logic [7:0] p,
			logic [15:0] c);
		rsp_t        w;
		int unsigned n;
		int unsigned fill;
		n = ring_span();
		w = '0;
		case (op)
			OP_WRITE: begin
				ring_mem[wr_ptr] = d;
				wr_ptr = (wr_ptr + 1) % n;
				if (overrun) rd_ptr = wr_ptr;
				else overrun = (wr_ptr == rd_ptr);
			end
			OP_READ: begin
				if (bytes_held() != 0) begin
					w.data = ring_mem[rd_ptr];
					drop_oldest(1);
				end
			end
			OP_PEEK: w.data = ring_mem[rd_ptr];
			OP_AT: begin
				if (p < bytes_held()) w.data = ring_mem[(rd_ptr + p) % n];
			end
			OP_FIND: begin
				fill = bytes_held();
				for (int unsigned i = 0; i < fill; i++) begin
					if (ring_mem[(rd_ptr + i) % n] == d) begin
						w.found  = 1'b1;
						w.offset = 8'(i);
						break;
					end
				end
			end
			OP_SEEK: begin
				while (bytes_held() != 0 && ring_mem[rd_ptr] != d) drop_oldest(1);
			end
			OP_SKIP: drop_oldest(c);
			default: drop_oldest(bytes_held());
		endcase
		fill   = bytes_held();
		w.fill = LEN_W'(fill);
		w.free = LEN_W'(n - fill);
		w.full = overrun;
		return w;
	endfunction

	// Status at full length with nothing overrun, for the directed rows
	function automatic rsp_t word_of(logic [7:0] d, logic f, logic [7:0] o, int fill);
		rsp_t w;
		w.data   = d;
		w.found  = f;
		w.offset = o;
		w.fill   = LEN_W'(fill);
		w.free   = LEN_W'(STORE_SIZE - fill);
		w.full   = 1'b0;
		return w;
	endfunction

	// Offer one word after a random gap; hold it until taken
	task automatic push_word(op_t op, logic [7:0] d, logic [7:0] p, logic [15:0] c,
			bit typed, rsp_t want);
		int   gap;
		rsp_t model_word;
		gap = tx_idle ? $urandom_range(0, 5) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		data_byte  <= d;
		position   <= p;
		skip_count <= c;
		do @(posedge clk); while (!in_ready);
		model_word = ring_predict(op, d, p, c);
		pending_words.push_back(typed ? want : model_word);
		if ($urandom_range(0, 29) == 0) tx_idle = !tx_idle;
	endtask

	// Stop offering words until every status has come back
	task automatic drain_then_hold(int extra);
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_length(logic [LEN_W-1:0] v);
		cfg_valid   <= 1'b1;
		ring_length <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_length(v);
	endtask

	// Random word, biased towards contents that are actually held
	task automatic random_word();
		int unsigned n;
		int unsigned have;
		op_t         op;
		logic [7:0]  d;
		logic [7:0]  p;
		logic [15:0] c;
		n    = ring_span();
		have = bytes_held();
		if ($urandom_range(0, 99) < write_pct) op = OP_WRITE;
		else op = op_t'($urandom_range(1, 7));
		// keep flushes rare so the ring gets deep
		if (op == OP_FLUSH && $urandom_range(0, 2) != 0) op = OP_FIND;
		if ((op == OP_FIND || op == OP_SEEK) && have != 0 && $urandom_range(0, 1))
			d = ring_mem[(rd_ptr + $urandom_range(0, have - 1)) % n];
		else if ($urandom_range(0, 1))
			d = 8'($urandom_range(0, 7));
		else
			d = 8'($urandom);
		if ($urandom_range(0, 1))
			p = 8'($urandom_range(0, have > 255 ? 255 : have));
		else
			p = 8'($urandom);
		case ($urandom_range(0, 4))
			0, 1:    c = 16'($urandom_range(0, 3));
			2, 3:    c = 16'($urandom_range(0, have + 2));
			default: c = 16'($urandom);
		endcase
		push_word(op, d, p, c, 1'b0, '0);
	endtask

	// Cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[overwriting_byte_ring_buffer_core] ERROR");
			$finish;
		end
	end

	// Take status words with random stalls and compare against the oldest expectation
	initial begin : status_sink
		rsp_t got;
		rsp_t want;
		int   stall;
		forever begin
			stall = rx_idle ? $urandom_range(0, 5) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.data   = data_out;
			got.found  = found;
			got.offset = found_offset;
			got.fill   = fill_level;
			got.free   = free_space;
			got.full   = full_flag;
			if (pending_words.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected word at %0t: data %02h fill %0d", $realtime,
						got.data, got.fill);
			end else begin
				want = pending_words.pop_front();
				if (got.data !== want.data || got.found !== want.found ||
						got.offset !== want.offset || got.fill !== want.fill ||
						got.free !== want.free || got.full !== want.full) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch at %0t:", $realtime,
							" got data %02h found %0d offset %02h fill %0d free %0d full %0d,",
							got.data, got.found, got.offset, got.fill, got.free, got.full,
							" want data %02h found %0d offset %02h fill %0d free %0d full %0d",
							want.data, want.found, want.offset, want.fill, want.free,
							want.full);
				end
			end
			if ($urandom_range(0, 39) == 0) rx_idle = !rx_idle;
		end
	end

	// Stimulus: directed rows, then phases at several ring lengths
	initial begin : stimulus
		logic [LEN_W-1:0] len_v;
		int               n_burst;
		apply_length(LEN_RESET);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		plan = '{
			'{OP_READ,  8'h00, 8'h00, 16'h0000, 1'b1, word_of(8'h00, 1'b0, 8'h00, 0)},
			'{OP_PEEK,  8'h00, 8'h00, 16'h0000, 1'b1, word_of(8'h00, 1'b0, 8'h00, 0)},
			'{OP_AT,    8'h00, 8'hFF, 16'h0000, 1'b1, word_of(8'h00, 1'b0, 8'h00, 0)},
			'{OP_FIND,  8'h00, 8'h00, 16'h0000, 1'b1, word_of(8'h00, 1'b0, 8'h00, 0)},
			'{OP_SEEK,  8'hAA, 8'h00, 16'h0000, 1'b1, word_of(8'h00, 1'b0, 8'h00, 0)},
			'{OP_SKIP,  8'h00, 8'h00, 16'hFFFF, 1'b1, word_of(8'h00, 1'b0, 8'h00, 0)},
			'{OP_FLUSH, 8'h00, 8'h00, 16'h0000, 1'b1, word_of(8'h00, 1'b0, 8'h00, 0)},
			'{OP_WRITE, 8'hFF, 8'h00, 16'h0000, 1'b1, word_of(8'h00, 1'b0, 8'h00, 1)},
			'{OP_WRITE, 8'h00, 8'hFF, 16'hFFFF, 1'b1, word_of(8'h00, 1'b0, 8'h00, 2)},
			'{OP_WRITE, 8'hA5, 8'h00, 16'h0000, 1'b1, word_of(8'h00, 1'b0, 8'h00, 3)},
			'{OP_PEEK,  8'h00, 8'h00, 16'h0000, 1'b1, word_of(8'hFF, 1'b0, 8'h00, 3)},
			'{OP_AT,    8'h00, 8'h02, 16'h0000, 1'b1, word_of(8'hA5, 1'b0, 8'h00, 3)},
			'{OP_AT,    8'h00, 8'h03, 16'h0000, 1'b1, word_of(8'h00, 1'b0, 8'h00, 3)},
			'{OP_FIND,  8'hA5, 8'h00, 16'h0000, 1'b1, word_of(8'h00, 1'b1, 8'h02, 3)},
			'{OP_FIND,  8'h5A, 8'h00, 16'h0000, 1'b1, word_of(8'h00, 1'b0, 8'h00, 3)},
			'{OP_FIND,  8'hFF, 8'h00, 16'h0000, 1'b1, word_of(8'h00, 1'b1, 8'h00, 3)},
			'{OP_READ,  8'h00, 8'h00, 16'h0000, 1'b1, word_of(8'hFF, 1'b0, 8'h00, 2)},
			'{OP_SEEK,  8'hA5, 8'h00, 16'h0000, 1'b1, word_of(8'h00, 1'b0, 8'h00, 1)},
			'{OP_WRITE, 8'h3C, 8'h00, 16'h0000, 1'b0, word_of(8'h00, 1'b0, 8'h00, 0)},
			'{OP_SKIP,  8'h00, 8'h00, 16'h0001, 1'b0, word_of(8'h00, 1'b0, 8'h00, 0)},
			'{OP_SKIP,  8'h00, 8'h00, 16'hFFFF, 1'b1, word_of(8'h00, 1'b0, 8'h00, 0)},
			'{OP_PEEK,  8'h00, 8'h00, 16'h0000, 1'b0, word_of(8'h00, 1'b0, 8'h00, 0)},
			'{OP_WRITE, 8'h11, 8'h00, 16'h0000, 1'b0, word_of(8'h00, 1'b0, 8'h00, 0)},
			'{OP_FLUSH, 8'h00, 8'h00, 16'h0000, 1'b1, word_of(8'h00, 1'b0, 8'h00, 0)},
			'{OP_READ,  8'h00, 8'h00, 16'h0000, 1'b0, word_of(8'h00, 1'b0, 8'h00, 0)}
		};
		foreach (plan[i])
			push_word(plan[i].op, plan[i].d, plan[i].p, plan[i].c, plan[i].typed,
				plan[i].want);

		for (int ph = 0; ph < 10; ph++) begin
			// change the length only once the ring has gone quiet
			if (ph != 0) begin
				drain_then_hold(8);
				case (ph)
					1:       len_v = LEN_W'(1);
					2:       len_v = LEN_W'(0);
					3:       len_v = LEN_W'(511);
					4:       len_v = LEN_W'(2);
					5:       len_v = LEN_W'(5);
					6:       len_v = LEN_W'(300);
					7:       len_v = LEN_W'($urandom_range(3, 40));
					8:       len_v = LEN_W'(256);
					default: len_v = LEN_W'($urandom_range(6, 64));
				endcase
				write_length(len_v);
			end
			write_pct = $urandom_range(35, 65);
			// fill to the length and up to four bytes past it, so that a full ring and often overwrite are reached
			if (ph == 3 || (ph != 0 && ring_span() <= 64)) begin
				n_burst = ring_span() + $urandom_range(0, 4);
				repeat (n_burst)
					push_word(OP_WRITE, 8'($urandom), 8'($urandom), 16'($urandom), 1'b0, '0);
			end
			for (int k = 0; k < 75; k++) begin
				if ($urandom_range(0, 49) == 0) drain_then_hold(0);
				random_word();
			end
		end

		drain_then_hold(300);
		if (fail_count == 0)
			$display("[overwriting_byte_ring_buffer_core] OK");
		else
			$display("[overwriting_byte_ring_buffer_core] ERROR");
		$finish;
	end

endmodule
